/* rtl/core/srd_pkg.sv */
`timescale 1ns / 1ps

package srd_pkg;

  typedef struct packed {
    logic vld;
    logic dz;
    logic ovf;
    logic qneg;
    logic rneg;
  } srd_ctl_t;

endpackage

/* rtl/core/srd_pre.sv */
`timescale 1ns / 1ps

module srd_pre #(
  parameter int WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [WIDTH-1:0]      dividend,
  input  logic [WIDTH-1:0]      divisor,
  output srd_pkg::srd_ctl_t     out_ctl,
  output logic [WIDTH-1:0]      out_acc,
  output logic [WIDTH-1:0]      out_nq,
  output logic [WIDTH-1:0]      out_d
);
  import srd_pkg::*;

  localparam logic [WIDTH-1:0] MostNeg = {1'b1, {(WIDTH-1){1'b0}}};

  srd_ctl_t         ctl_r, ctl_nxt;
  logic [WIDTH-1:0] nq_r, nq_nxt;
  logic [WIDTH-1:0] d_r, d_nxt;

  always_comb begin
    ctl_nxt.vld  = in_vld;
    ctl_nxt.dz   = (divisor == '0);
    ctl_nxt.ovf  = (dividend == MostNeg) && (divisor == '1);
    ctl_nxt.qneg = dividend[WIDTH-1] ^ divisor[WIDTH-1];
    ctl_nxt.rneg = dividend[WIDTH-1];
    nq_nxt = dividend[WIDTH-1] ? (-dividend) : dividend;
    d_nxt  = divisor[WIDTH-1] ? (-divisor) : divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq_r <= nq_nxt;
      d_r  <= d_nxt;
    end
  end

  assign out_ctl = ctl_r;
  assign out_acc = '0;
  assign out_nq  = nq_r;
  assign out_d   = d_r;

endmodule

/* rtl/core/srd_cell.sv */
`timescale 1ns / 1ps

module srd_cell #(
  parameter int WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  srd_pkg::srd_ctl_t     in_ctl,
  input  logic [WIDTH-1:0]      in_acc,
  input  logic [WIDTH-1:0]      in_nq,
  input  logic [WIDTH-1:0]      in_d,
  output srd_pkg::srd_ctl_t     out_ctl,
  output logic [WIDTH-1:0]      out_acc,
  output logic [WIDTH-1:0]      out_nq,
  output logic [WIDTH-1:0]      out_d
);
  import srd_pkg::*;

  srd_ctl_t         ctl_r;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] nq_r, nq_nxt;
  logic [WIDTH-1:0] d_r;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             ge;

  always_comb begin
    trial   = {in_acc, in_nq[WIDTH-1]};
    ge      = (trial >= {1'b0, in_d});
    diff    = trial - {1'b0, in_d};
    acc_nxt = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    nq_nxt  = {in_nq[WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      nq_r  <= nq_nxt;
      d_r   <= in_d;
    end
  end

  assign out_ctl = ctl_r;
  assign out_acc = acc_r;
  assign out_nq  = nq_r;
  assign out_d   = d_r;

endmodule

/* rtl/core/srd_post.sv */
`timescale 1ns / 1ps

module srd_post #(
  parameter int WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  srd_pkg::srd_ctl_t     in_ctl,
  input  logic [WIDTH-1:0]      in_qmag,
  input  logic [WIDTH-1:0]      in_rmag,
  output logic                  out_vld,
  output logic [WIDTH-1:0]      quotient,
  output logic [WIDTH-1:0]      remainder,
  output logic                  div_by_zero,
  output logic                  overflow
);
  import srd_pkg::*;

  localparam logic [WIDTH-1:0] MaxPos = {1'b0, {(WIDTH-1){1'b1}}};

  logic             vld_r;
  logic             dz_r, dz_nxt;
  logic             ovf_r, ovf_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;

  always_comb begin
    dz_nxt  = in_ctl.dz;
    ovf_nxt = in_ctl.ovf && !in_ctl.dz;
    if (in_ctl.dz) begin
      quo_nxt = '0;
      rem_nxt = '0;
    end else if (in_ctl.ovf) begin
      quo_nxt = MaxPos;
      rem_nxt = '0;
    end else begin
      quo_nxt = in_ctl.qneg ? (-in_qmag) : in_qmag;
      rem_nxt = in_ctl.rneg ? (-in_rmag) : in_rmag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz_r  <= dz_nxt;
      ovf_r <= ovf_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign out_vld     = vld_r;
  assign quotient    = quo_r;
  assign remainder   = rem_r;
  assign div_by_zero = dz_r;
  assign overflow    = ovf_r;

endmodule

/* rtl/core/signed_restoring_divider.sv */
`timescale 1ns / 1ps
// Channel  | Direction | Handshake          | Payload
// in_      | slave     | in_tvalid/tready   | tdata: dividend, divisor
// out_     | master    | out_tvalid/tready  | tdata: quotient, remainder;
//          |           |                    | tuser: div_by_zero, overflow
// One word accepted per cycle while in_tready is high; each word passes from
// input to output through an operand register, a chain of WIDTH restoring-step
// cells and an output register. Synchronous active-low reset empties the chain.
// While the output word waits with out_tready low, the whole chain holds and
// in_tready drops; an empty output register lets the chain advance.

module signed_restoring_divider #(
  parameter int WIDTH = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((2*WIDTH+7)/8)*8-1:0]           in_tdata,   // dividend, divisor
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((2*WIDTH+7)/8)*8-1:0]           out_tdata,  // quotient, remainder
  output logic [1:0]                             out_tuser   // div_by_zero, overflow
);
  import srd_pkg::*;

  localparam logic [WIDTH-1:0] MaxPos = {1'b0, {(WIDTH-1){1'b1}}};

  logic             en;
  srd_ctl_t         ctl_s [0:WIDTH];
  logic [WIDTH-1:0] acc_s [0:WIDTH];
  logic [WIDTH-1:0] nq_s  [0:WIDTH];
  logic [WIDTH-1:0] d_s   [0:WIDTH];
  logic [WIDTH-1:0] quotient;
  logic [WIDTH-1:0] remainder;
  logic             div_by_zero;
  logic             overflow;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  srd_pre #(.WIDTH(WIDTH)) u_pre (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_tvalid),
    .dividend (in_tdata[WIDTH-1:0]),
    .divisor  (in_tdata[2*WIDTH-1:WIDTH]),
    .out_ctl  (ctl_s[0]),
    .out_acc  (acc_s[0]),
    .out_nq   (nq_s[0]),
    .out_d    (d_s[0])
  );

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    srd_cell #(.WIDTH(WIDTH)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_ctl  (ctl_s[i]),
      .in_acc  (acc_s[i]),
      .in_nq   (nq_s[i]),
      .in_d    (d_s[i]),
      .out_ctl (ctl_s[i+1]),
      .out_acc (acc_s[i+1]),
      .out_nq  (nq_s[i+1]),
      .out_d   (d_s[i+1])
    );
  end

  srd_post #(.WIDTH(WIDTH)) u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_ctl      (ctl_s[WIDTH]),
    .in_qmag     (nq_s[WIDTH]),
    .in_rmag     (acc_s[WIDTH]),
    .out_vld     (out_tvalid),
    .quotient    (quotient),
    .remainder   (remainder),
    .div_by_zero (div_by_zero),
    .overflow    (overflow)
  );

  always_comb begin
    out_tdata                    = '0;
    out_tdata[WIDTH-1:0]         = quotient;
    out_tdata[2*WIDTH-1:WIDTH]   = remainder;
    out_tuser                    = {overflow, div_by_zero};
  end

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("div_by_zero and overflow both set");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[2*WIDTH-1:0] == '0))
    else $error("divide by zero word with nonzero results");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |->
      (out_tdata[WIDTH-1:0] == MaxPos && out_tdata[2*WIDTH-1:WIDTH] == '0))
    else $error("overflow word not saturated");

endmodule

/* tb/srd_result_checker.sv */
`timescale 1ns / 1ps

module srd_result_checker #(
  parameter int WIDTH = 8,
  parameter int DW    = ((2*WIDTH+7)/8)*8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tready,
  input  logic [DW-1:0] in_tdata,
  input  logic          out_tvalid,
  input  logic          out_tready,
  input  logic [DW-1:0] out_tdata,
  input  logic [1:0]    out_tuser,
  output int            err_count,
  output int            pending
);

  typedef struct packed {
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
    logic             div_by_zero;
    logic             overflow;
  } quot_rem_t;

  quot_rem_t awaited_quotients[$];

  function automatic quot_rem_t divide_pair(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
    logic [WIDTH-1:0] na;
    logic [WIDTH-1:0] nb;
    logic [WIDTH-1:0] qm;
    logic [WIDTH:0]   acc;
    logic             a_neg;
    logic             b_neg;
    quot_rem_t        res;
    res   = '0;
    a_neg = a[WIDTH-1];
    b_neg = b[WIDTH-1];
    if (b == '0) begin
      res.div_by_zero = 1'b1;
    end else if (a == {1'b1, {(WIDTH-1){1'b0}}} && b == {WIDTH{1'b1}}) begin
      res.quotient = {1'b0, {(WIDTH-1){1'b1}}};
      res.overflow = 1'b1;
    end else begin
      na  = a_neg ? -a : a;
      nb  = b_neg ? -b : b;
      acc = '0;
      qm  = '0;
      for (int i = WIDTH-1; i >= 0; i--) begin
        acc = {acc[WIDTH-1:0], na[i]};
        if (acc >= {1'b0, nb}) begin
          acc   = acc - {1'b0, nb};
          qm[i] = 1'b1;
        end
      end
      res.quotient  = (a_neg != b_neg) ? -qm : qm;
      res.remainder = a_neg ? -acc[WIDTH-1:0] : acc[WIDTH-1:0];
    end
    return res;
  endfunction

  initial begin
    err_count = 0;
    pending   = 0;
  end

  always @(posedge clk) begin
    quot_rem_t want;
    quot_rem_t got;
    if (!rst_n) begin
      awaited_quotients.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.quotient    = out_tdata[WIDTH-1:0];
        got.remainder   = out_tdata[2*WIDTH-1:WIDTH];
        got.div_by_zero = out_tuser[0];
        got.overflow    = out_tuser[1];
        if (awaited_quotients.size() == 0) begin
          $error("unexpected word: quotient %0d remainder %0d",
                 $signed(got.quotient), $signed(got.remainder));
          err_count++;
        end else begin
          want = awaited_quotients.pop_front();
          if (got.quotient !== want.quotient) begin
            $error("quotient: expected %0d, actual %0d",
                   $signed(want.quotient), $signed(got.quotient));
            err_count++;
          end
          if (got.remainder !== want.remainder) begin
            $error("remainder: expected %0d, actual %0d",
                   $signed(want.remainder), $signed(got.remainder));
            err_count++;
          end
          if (got.div_by_zero !== want.div_by_zero) begin
            $error("div_by_zero: expected %0b, actual %0b",
                   want.div_by_zero, got.div_by_zero);
            err_count++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
            err_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        awaited_quotients.insert(awaited_quotients.size(),
                                 divide_pair(in_tdata[WIDTH-1:0],
                                             in_tdata[2*WIDTH-1:WIDTH]));
    end
    pending = awaited_quotients.size();
  end

endmodule

/* tb/tb_signed_restoring_divider.sv */
`timescale 1ns / 1ps

module tb_signed_restoring_divider;

  localparam int WIDTH      = 8;
  localparam int DW         = ((2*WIDTH+7)/8)*8;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN      = 2*(WIDTH+2);
  localparam int RAND_ITEMS = 2000;

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          in_tvalid  = 1'b0;
  logic          in_tready;
  logic [DW-1:0] in_tdata   = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [DW-1:0] out_tdata;
  logic [1:0]    out_tuser;

  int err_count;
  int pending;
  int cycle_count = 0;
  int rx_wait     = 0;
  int rx_taken    = 0;
  bit rx_burst    = 1'b0;
  bit rx_hit      = 1'b0;
  bit tx_burst    = 1'b0;

  always #2 clk = ~clk;

  signed_restoring_divider #(.WIDTH(WIDTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  srd_result_checker #(.WIDTH(WIDTH)) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .err_count  (err_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    rx_hit      <= rst_n && out_tvalid && out_tready;
    if (cycle_count == CYCLE_CAP) begin
      $display("signed_restoring_divider: mismatch");
      $finish;
    end
  end

  // stall the result side for a random wait after each word taken, none in a burst
  always @(negedge clk) begin
    if (rx_hit) begin
      rx_taken++;
      if (rx_taken % 64 == 0)
        rx_burst = ($urandom_range(0, 3) == 0);
      rx_wait = rx_burst ? 0 : $urandom_range(0, 13);
    end
    if (rst_n && rx_wait == 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      if (rx_wait > 0)
        rx_wait--;
    end
  end

  task automatic send_word(logic [WIDTH-1:0] dividend, logic [WIDTH-1:0] divisor, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(DW-2*WIDTH){1'b0}}, divisor, dividend};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int draw_gap();
    return tx_burst ? 0 : $urandom_range(0, 13);
  endfunction

  initial begin
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    int               kind;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, zero divisor, overflow, sign combinations
    send_word(8'sd0,    8'sd1,    draw_gap());
    send_word(8'sd127,  8'sd1,    draw_gap());
    send_word(-8'sd128, 8'sd1,    draw_gap());
    send_word(-8'sd128, -8'sd1,   draw_gap());
    send_word(-8'sd128, 8'sd0,    draw_gap());
    send_word(8'sd0,    8'sd0,    draw_gap());
    send_word(8'sd127,  8'sd0,    draw_gap());
    send_word(8'sd127,  -8'sd1,   draw_gap());
    send_word(-8'sd128, 8'sd127,  draw_gap());
    send_word(8'sd127,  -8'sd128, draw_gap());
    send_word(-8'sd128, -8'sd128, draw_gap());
    send_word(8'sd127,  8'sd127,  draw_gap());
    send_word(-8'sd1,   -8'sd1,   draw_gap());
    send_word(8'sd1,    -8'sd1,   draw_gap());
    send_word(-8'sd1,   8'sd1,    draw_gap());
    send_word(8'sd7,    8'sd2,    draw_gap());
    send_word(-8'sd7,   8'sd2,    draw_gap());
    send_word(8'sd7,    -8'sd2,   draw_gap());
    send_word(-8'sd7,   -8'sd2,   draw_gap());
    send_word(8'sd6,    8'sd3,    draw_gap());
    send_word(-8'sd6,   8'sd3,    draw_gap());
    send_word(8'sd5,    8'sd127,  draw_gap());
    send_word(-8'sd1,   -8'sd128, draw_gap());
    send_word(8'sd100,  -8'sd7,   draw_gap());

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 64 == 0)
        tx_burst = ($urandom_range(0, 3) == 0);
      a    = WIDTH'($urandom());
      b    = WIDTH'($urandom());
      kind = $urandom_range(0, 15);
      case (kind)
        0: b = '0;
        1: begin
          a = {1'b1, {(WIDTH-1){1'b0}}};
          if ($urandom_range(0, 1) == 0)
            b = {WIDTH{1'b1}};
        end
        2: b = $urandom_range(0, 1) ? WIDTH'($urandom_range(1, 3))
                                    : WIDTH'(-$urandom_range(1, 3));
        3: a = $urandom_range(0, 1) ? WIDTH'($urandom_range(0, 3))
                                    : WIDTH'(-$urandom_range(0, 3));
        default: ;
      endcase
      send_word(a, b, draw_gap());
    end
    in_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN) @(negedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("signed_restoring_divider: match");
    end else begin
      $display("signed_restoring_divider: mismatch");
    end
    $finish;
  end

endmodule

/* signed_restoring_divider.f */
rtl/core/srd_pkg.sv
rtl/core/srd_pre.sv
rtl/core/srd_cell.sv
rtl/core/srd_post.sv
rtl/core/signed_restoring_divider.sv
tb/srd_result_checker.sv
tb/tb_signed_restoring_divider.sv
